### design/ipv4hrc_pkg.sv
// ----------------------------------------------------------------------------
// ipv4hrc_pkg
// Shared constants and controller/datapath interface types for the IPv4
// header rewrite and checksum core.
// ----------------------------------------------------------------------------
package ipv4hrc_pkg;

    localparam int HDR_READ_BYTES = 24;
    localparam int HDR_OUT_BYTES  = 20;
    localparam int STORE_BYTES    = 10;
    localparam int ACC_W          = 20;

    localparam int POS_W   = $clog2(HDR_READ_BYTES);
    localparam int EMIT_W  = $clog2(HDR_OUT_BYTES);
    localparam int STORE_AW = $clog2(STORE_BYTES);

    localparam int LEN_W  = 16;
    localparam int ADDR_W = 32;

    localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(3);

    localparam logic [EMIT_W-1:0] B_CSUM_HI = EMIT_W'(10);
    localparam logic [EMIT_W-1:0] B_CSUM_LO = EMIT_W'(11);
    localparam logic [EMIT_W-1:0] B_SRC_0   = EMIT_W'(12);
    localparam logic [EMIT_W-1:0] B_SRC_1   = EMIT_W'(13);
    localparam logic [EMIT_W-1:0] B_SRC_2   = EMIT_W'(14);
    localparam logic [EMIT_W-1:0] B_SRC_3   = EMIT_W'(15);
    localparam logic [EMIT_W-1:0] B_DST_0   = EMIT_W'(16);
    localparam logic [EMIT_W-1:0] B_DST_1   = EMIT_W'(17);
    localparam logic [EMIT_W-1:0] B_DST_2   = EMIT_W'(18);
    localparam logic [EMIT_W-1:0] B_DST_3   = EMIT_W'(19);

    typedef struct packed {
        logic hdr_take;
        logic skip_take;
        logic sum_step;
        logic fold;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic pos_last;
        logic sum_last;
        logic emit_last;
        logic remain_one;
        logic len_long;
    } sts_t;

endpackage

### design/ipv4_header_rewrite_checksum_core.sv
// ----------------------------------------------------------------------------
// ipv4_header_rewrite_checksum_core
// Rewrites IPv4 source/destination addresses and regenerates the header
// checksum on a byte stream.
// ----------------------------------------------------------------------------
// Header and payload bytes are taken one per cycle while the core is ready for
// input. The replacement addresses are sampled with the first header byte.
// After the 24th header byte the core adds the four address words and folds
// the sum, then emits the 20 rewritten header bytes, one per cycle while the
// sink is ready, tlast on the final byte; input is held off until the last
// header byte is loaded. The next (total length - 24) bytes are consumed
// without output at one per cycle. The last header byte may still be waiting
// at the output while the core already takes the following bytes.
module ipv4_header_rewrite_checksum_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // data_byte, new_source_address, new_dest_address
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tlast
);

    ipv4hrc_pkg::cmd_t cmd;
    ipv4hrc_pkg::sts_t sts;

    ipv4hrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ipv4hrc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_byte  (s_axis_tdata[7:0]),
        .in_src   (s_axis_tdata[39:8]),
        .in_dst   (s_axis_tdata[71:40]),
        .out_byte (m_axis_tdata),
        .out_last (m_axis_tlast)
    );

    a_take_needs_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.hdr_take || cmd.skip_take) |-> (s_axis_tvalid && s_axis_tready))
        else $error("input consumed without a transaction");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.hdr_take, cmd.skip_take, cmd.sum_step, cmd.fold, cmd.emit_load}))
        else $error("more than one datapath command at once");

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load && sts.emit_last) |=> !cmd.emit_load)
        else $error("header byte loaded after the last one");

    a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> !s_axis_tready)
        else $error("input ready during header emission");

endmodule

### design/ipv4hrc_dp.sv
// ----------------------------------------------------------------------------
// ipv4hrc_dp
// Datapath: header byte store, length capture, running ones-complement sum,
// checksum fold, payload skip counter and the output byte register.
// ----------------------------------------------------------------------------
module ipv4hrc_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ipv4hrc_pkg::cmd_t      cmd,
    output ipv4hrc_pkg::sts_t      sts,
    input  logic [7:0]             in_byte,
    input  logic [31:0]            in_src,
    input  logic [31:0]            in_dst,
    output logic [7:0]             out_byte,
    output logic                   out_last
);

    logic [7:0]                       hdr_reg [ipv4hrc_pkg::STORE_BYTES];
    logic [ipv4hrc_pkg::POS_W-1:0]    pos_reg;
    logic [1:0]                       sum_idx_reg;
    logic [ipv4hrc_pkg::EMIT_W-1:0]   emit_idx_reg;
    logic [ipv4hrc_pkg::LEN_W-1:0]    remain_reg;
    logic [ipv4hrc_pkg::LEN_W-1:0]    len_reg;
    logic [ipv4hrc_pkg::ADDR_W-1:0]   src_reg;
    logic [ipv4hrc_pkg::ADDR_W-1:0]   dst_reg;
    logic [ipv4hrc_pkg::ACC_W-1:0]    acc_reg;
    logic [15:0]                      csum_reg;
    logic [7:0]                       out_byte_reg;
    logic                             out_last_reg;

    logic                             pos_in_store;
    logic [ipv4hrc_pkg::STORE_AW-1:0] prev_idx;
    logic [15:0]                      addr_word;
    logic [16:0]                      fold1;
    logic [15:0]                      fold2;
    logic [7:0]                       emit_byte_next;

    assign pos_in_store = pos_reg < ipv4hrc_pkg::POS_W'(ipv4hrc_pkg::STORE_BYTES);
    assign prev_idx     = pos_reg[ipv4hrc_pkg::STORE_AW-1:0] - ipv4hrc_pkg::STORE_AW'(1);

    always_comb
    begin
        unique case (sum_idx_reg)
            2'd0:    addr_word = src_reg[31:16];
            2'd1:    addr_word = src_reg[15:0];
            2'd2:    addr_word = dst_reg[31:16];
            default: addr_word = dst_reg[15:0];
        endcase
    end

    assign fold1 = 17'(acc_reg[15:0]) + 17'(acc_reg[ipv4hrc_pkg::ACC_W-1:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    always_comb
    begin
        unique case (emit_idx_reg)
            ipv4hrc_pkg::B_CSUM_HI: emit_byte_next = csum_reg[15:8];
            ipv4hrc_pkg::B_CSUM_LO: emit_byte_next = csum_reg[7:0];
            ipv4hrc_pkg::B_SRC_0:   emit_byte_next = src_reg[31:24];
            ipv4hrc_pkg::B_SRC_1:   emit_byte_next = src_reg[23:16];
            ipv4hrc_pkg::B_SRC_2:   emit_byte_next = src_reg[15:8];
            ipv4hrc_pkg::B_SRC_3:   emit_byte_next = src_reg[7:0];
            ipv4hrc_pkg::B_DST_0:   emit_byte_next = dst_reg[31:24];
            ipv4hrc_pkg::B_DST_1:   emit_byte_next = dst_reg[23:16];
            ipv4hrc_pkg::B_DST_2:   emit_byte_next = dst_reg[15:8];
            ipv4hrc_pkg::B_DST_3:   emit_byte_next = dst_reg[7:0];
            default:
            begin
                if (emit_idx_reg < ipv4hrc_pkg::EMIT_W'(ipv4hrc_pkg::STORE_BYTES))
                    emit_byte_next = hdr_reg[emit_idx_reg[ipv4hrc_pkg::STORE_AW-1:0]];
                else
                    emit_byte_next = '0;
            end
        endcase
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sum_idx_reg  <= '0;
            emit_idx_reg <= '0;
            remain_reg   <= '0;
        end
        else
        begin
            if (cmd.hdr_take)
            begin
                if (sts.pos_last)
                    pos_reg <= '0;
                else
                    pos_reg <= pos_reg + ipv4hrc_pkg::POS_W'(1);
            end
            if (cmd.sum_step)
                sum_idx_reg <= sum_idx_reg + 2'd1;
            if (cmd.emit_load)
            begin
                if (sts.emit_last)
                    emit_idx_reg <= '0;
                else
                    emit_idx_reg <= emit_idx_reg + ipv4hrc_pkg::EMIT_W'(1);
            end
            if (cmd.fold)
                remain_reg <= len_reg - ipv4hrc_pkg::LEN_W'(ipv4hrc_pkg::HDR_READ_BYTES);
            else if (cmd.skip_take)
                remain_reg <= remain_reg - ipv4hrc_pkg::LEN_W'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.hdr_take)
        begin
            if (pos_reg == '0)
            begin
                src_reg <= in_src;
                dst_reg <= in_dst;
                acc_reg <= '0;
            end
            else if (pos_in_store && pos_reg[0])
                acc_reg <= acc_reg + ipv4hrc_pkg::ACC_W'({hdr_reg[prev_idx], in_byte});
            if (pos_in_store)
                hdr_reg[pos_reg[ipv4hrc_pkg::STORE_AW-1:0]] <= in_byte;
            if (pos_reg == ipv4hrc_pkg::POS_LEN_HI)
                len_reg[15:8] <= in_byte;
            if (pos_reg == ipv4hrc_pkg::POS_LEN_LO)
                len_reg[7:0] <= in_byte;
        end
        if (cmd.sum_step)
            acc_reg <= acc_reg + ipv4hrc_pkg::ACC_W'(addr_word);
        if (cmd.fold)
            csum_reg <= ~fold2;
        if (cmd.emit_load)
        begin
            out_byte_reg <= emit_byte_next;
            out_last_reg <= sts.emit_last;
        end
    end

    assign sts.pos_last   = pos_reg == ipv4hrc_pkg::POS_W'(ipv4hrc_pkg::HDR_READ_BYTES - 1);
    assign sts.sum_last   = sum_idx_reg == 2'd3;
    assign sts.emit_last  = emit_idx_reg == ipv4hrc_pkg::EMIT_W'(ipv4hrc_pkg::HDR_OUT_BYTES - 1);
    assign sts.remain_one = remain_reg == ipv4hrc_pkg::LEN_W'(1);
    assign sts.len_long   = len_reg > ipv4hrc_pkg::LEN_W'(ipv4hrc_pkg::HDR_READ_BYTES);

    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;

endmodule

### design/ipv4hrc_ctrl.sv
// ----------------------------------------------------------------------------
// ipv4hrc_ctrl
// Controller: sequences header capture, address word summing, checksum fold,
// header emission and payload skipping.
// ----------------------------------------------------------------------------
module ipv4hrc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ipv4hrc_pkg::sts_t sts,
    output ipv4hrc_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_HDR,
        S_SUM,
        S_FOLD,
        S_EMIT,
        S_SKIP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_xfer;
    logic   out_free;

    assign in_ready = (state_reg == S_HDR) || (state_reg == S_SKIP);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_HDR:
            begin
                cmd.hdr_take = in_xfer;
                if (in_xfer && sts.pos_last)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.sum_last)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit_load  = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.emit_last)
                        state_next = sts.len_long ? S_SKIP : S_HDR;
                end
            end
            S_SKIP:
            begin
                cmd.skip_take = in_xfer;
                if (in_xfer && sts.remain_one)
                    state_next = S_HDR;
            end
            default:
            begin
                state_next = S_HDR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_HDR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### dv/ipv4_header_rewrite_checksum_core_tb.sv
// ----------------------------------------------------------------------------
// ipv4_header_rewrite_checksum_core_tb
// Streams packets into the core and checks the rewritten 20-byte headers.
// An in-bench model tracks the header bytes, the length and the payload skip,
// and it recomputes the checksum with the new addresses. Every output
// transaction is compared with the oldest predicted byte. Both sides idle at
// random, and one long output stall lets the core back up onto its input.
// ----------------------------------------------------------------------------
module ipv4_header_rewrite_checksum_core_tb;

    typedef logic [7:0] hdr_bytes_t [ipv4hrc_pkg::HDR_READ_BYTES];

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } hdr_out_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;    // data_byte, new_source_address, new_dest_address
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // out_byte
    logic        m_axis_tlast;

    hdr_out_t    rewritten_bytes[$];
    int          mismatch_count;
    bit          idle_on;
    bit          hold_req;
    int          hold_left;

    logic [7:0]  hdr_seen [ipv4hrc_pkg::HDR_OUT_BYTES];
    int          hdr_pos;
    bit          skipping;
    logic [15:0] skip_left;
    logic [15:0] pkt_len;
    logic [31:0] src_held;
    logic [31:0] dst_held;

    ipv4_header_rewrite_checksum_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    task automatic predict_rewrite(input logic [71:0] item);
        logic [7:0]  b;
        logic [31:0] acc;
        logic [15:0] csum;
        int          k;
        b = item[7:0];
        if (skipping)
        begin
            if (skip_left != 0)
                skip_left--;
            if (skip_left == 0)
                skipping = 1'b0;
            return;
        end
        if (hdr_pos == 0)
        begin
            src_held = item[39:8];
            dst_held = item[71:40];
        end
        if (hdr_pos < ipv4hrc_pkg::HDR_OUT_BYTES)
            hdr_seen[hdr_pos] = b;
        if (hdr_pos == 2)
            pkt_len[15:8] = b;
        else if (hdr_pos == 3)
            pkt_len[7:0] = b;
        if (hdr_pos + 1 < ipv4hrc_pkg::HDR_READ_BYTES)
        begin
            hdr_pos++;
            return;
        end
        hdr_pos = 0;
        for (k = 0; k < 4; k++)
        begin
            hdr_seen[12 + k] = src_held[31 - 8 * k -: 8];
            hdr_seen[16 + k] = dst_held[31 - 8 * k -: 8];
        end
        hdr_seen[10] = 8'h00;
        hdr_seen[11] = 8'h00;
        acc = 32'd0;
        for (k = 0; k < ipv4hrc_pkg::HDR_OUT_BYTES; k += 2)
            acc += {16'd0, hdr_seen[k], hdr_seen[k + 1]};
        acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        csum = ~acc[15:0];
        hdr_seen[10] = csum[15:8];
        hdr_seen[11] = csum[7:0];
        for (k = 0; k < ipv4hrc_pkg::HDR_OUT_BYTES; k++)
            rewritten_bytes.push_back('{out_byte: hdr_seen[k],
                last_byte: (k == ipv4hrc_pkg::HDR_OUT_BYTES - 1)});
        if (pkt_len > ipv4hrc_pkg::HDR_READ_BYTES)
        begin
            skip_left = pkt_len - 16'(ipv4hrc_pkg::HDR_READ_BYTES);
            skipping  = 1'b1;
        end
        else
        begin
            skip_left = 16'd0;
            skipping  = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            predict_rewrite(s_axis_tdata);
    end

    always @(posedge clk)
    begin : check_out
        hdr_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (rewritten_bytes.size() == 0)
            begin
                $error("out_byte: none expected, actual %02h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = rewritten_bytes.pop_front();
                if (m_axis_tdata !== want.out_byte)
                begin
                    $error("out_byte: expected %02h, actual %02h", want.out_byte, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last_byte)
                begin
                    $error("last_byte: expected %0b, actual %0b", want.last_byte, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // sink side: random idling, plus a long counted hold-off on request
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 299;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= !(idle_on && $urandom_range(99) < 7);
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic [31:0] src, input logic [31:0] dst);
        while (idle_on && $urandom_range(99) < 7)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dst, src, d};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // header bytes, then the payload the length calls for; addresses on
    // later bytes are random and must be ignored
    task automatic send_packet(input hdr_bytes_t hdr, input logic [31:0] src,
                               input logic [31:0] dst);
        logic [15:0] len;
        int          i;
        len = {hdr[2], hdr[3]};
        send_byte(hdr[0], src, dst);
        for (i = 1; i < ipv4hrc_pkg::HDR_READ_BYTES; i++)
            send_byte(hdr[i], $urandom, $urandom);
        if (len > ipv4hrc_pkg::HDR_READ_BYTES)
            for (i = 0; i < len - ipv4hrc_pkg::HDR_READ_BYTES; i++)
                send_byte(8'($urandom), $urandom, $urandom);
    endtask

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 16'($urandom_range(30));
        else
            return 16'($urandom_range(48, 31));
    endfunction

    task automatic send_random_packet();
        hdr_bytes_t  hdr;
        logic [15:0] len;
        int          i;
        len = pick_length();
        for (i = 0; i < ipv4hrc_pkg::HDR_READ_BYTES; i++)
            hdr[i] = 8'($urandom);
        hdr[2] = len[15:8];
        hdr[3] = len[7:0];
        send_packet(hdr, $urandom, $urandom);
    endtask

    task automatic test_directed();
        hdr_bytes_t hdr;
        int         i;
        // all zero, zero length: nothing skipped
        for (i = 0; i < ipv4hrc_pkg::HDR_READ_BYTES; i++)
            hdr[i] = 8'h00;
        send_packet(hdr, 32'h0000_0000, 32'h0000_0000);
        // zero length; word sum 0x1ffff needs the second carry fold
        hdr[0] = 8'hff;
        hdr[1] = 8'hff;
        hdr[4] = 8'hff;
        hdr[5] = 8'hff;
        hdr[7] = 8'h01;
        send_packet(hdr, 32'h0000_0000, 32'h0000_0000);
        // all ones, one payload byte, dropped header bytes all ones
        for (i = 0; i < ipv4hrc_pkg::HDR_READ_BYTES; i++)
            hdr[i] = 8'hff;
        hdr[2] = 8'h00;
        hdr[3] = 8'(ipv4hrc_pkg::HDR_READ_BYTES + 1);
        send_packet(hdr, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    task automatic test_random_packets(input int count);
        repeat (count)
            send_random_packet();
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        test_random_packets(4);
        idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        hdr_bytes_t hdr;
        int         i;
        hold_req = 1'b1;
        for (i = 0; i < ipv4hrc_pkg::HDR_READ_BYTES; i++)
            hdr[i] = 8'($urandom);
        hdr[2] = 8'h00;
        repeat (3)
        begin
            hdr[3] = 8'($urandom_range(ipv4hrc_pkg::HDR_READ_BYTES));
            send_packet(hdr, $urandom, $urandom);
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        hold_left      = 0;
        hdr_pos        = 0;
        skipping       = 1'b0;
        skip_left      = 16'd0;
        pkt_len        = 16'd0;
        src_held       = 32'd0;
        dst_held       = 32'd0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_packets(5);
        test_no_idle();
        test_output_stall();
        s_axis_tvalid <= 1'b0;

        while (rewritten_bytes.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
